// File: design/tcw_pkg.sv
// tcw_pkg: shared types and constants of the text console writer
// command codes, queue entry type and sequencer states; no dependencies
package tcw_pkg;

	localparam int ROWS_DEF        = 25;
	localparam int COLS_DEF        = 80;
	localparam int QUEUE_DEPTH_DEF = 2;

	// widest row and column index over the supported geometry
	localparam int ROW_W_MAX = 6;
	localparam int COL_W_MAX = 8;

	localparam logic [1:0] CMD_PUT   = 2'd0;
	localparam logic [1:0] CMD_READ  = 2'd1;
	localparam logic [1:0] CMD_CLEAR = 2'd2;

	localparam logic [7:0] NEWLINE_CHAR       = 8'd10;
	localparam logic [7:0] DEFAULT_ATTR_RESET = 8'd15;

	typedef enum logic [2:0] {
		OP_PUT,
		OP_NEWLINE,
		OP_READ,
		OP_CLEAR,
		OP_NOP
	} op_t;

	typedef struct packed {
		op_t                  op;
		logic [7:0]           ch;
		logic [7:0]           attr;
		logic                 at_cursor;
		logic [ROW_W_MAX-1:0] row;
		logic [COL_W_MAX-1:0] col;
	} cmd_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_EXEC,
		ST_SCROLL,
		ST_SCRBOT,
		ST_CLEAR,
		ST_DONE
	} state_t;

endpackage

// File: design/tcw_front.sv
// tcw_front: input side of the console writer
// decodes and saturates incoming items, holds the default attribute; uses tcw_pkg
module tcw_front #(
	parameter int ROWS = tcw_pkg::ROWS_DEF,
	parameter int COLS = tcw_pkg::COLS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [7:0]         cfg_data,
	input  logic               s_axis_tvalid,
	output logic               s_axis_tready,
	input  logic [31:0]        s_axis_tdata,  // ch, attr, at_cursor, row, col, zero pad
	input  logic [1:0]         s_axis_tuser,  // command
	output logic               push_valid,
	input  logic               push_ready,
	output tcw_pkg::cmd_t      push_cmd
);

	logic [7:0]                    dflt_attr_q;
	logic [7:0]                    in_ch;
	logic [7:0]                    in_attr;
	logic                          in_at_cursor;
	logic [tcw_pkg::ROW_W_MAX-1:0] in_row;
	logic [tcw_pkg::COL_W_MAX-1:0] in_col;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dflt_attr_q <= tcw_pkg::DEFAULT_ATTR_RESET;
		end else if (cfg_valid && cfg_ready) begin
			dflt_attr_q <= cfg_data;
		end
	end

	assign in_ch        = s_axis_tdata[7:0];
	assign in_attr      = s_axis_tdata[15:8];
	assign in_at_cursor = s_axis_tdata[16];
	assign in_row       = tcw_pkg::ROW_W_MAX'(s_axis_tdata[21:17]);
	assign in_col       = tcw_pkg::COL_W_MAX'(s_axis_tdata[28:22]);

	assign push_valid    = s_axis_tvalid;
	assign s_axis_tready = push_ready;

	always_comb begin
		push_cmd = '0;
		unique case (s_axis_tuser)
			tcw_pkg::CMD_PUT: begin
				push_cmd.op = (in_ch == tcw_pkg::NEWLINE_CHAR) ? tcw_pkg::OP_NEWLINE
					: tcw_pkg::OP_PUT;
			end
			tcw_pkg::CMD_READ:  push_cmd.op = tcw_pkg::OP_READ;
			tcw_pkg::CMD_CLEAR: push_cmd.op = tcw_pkg::OP_CLEAR;
			default:            push_cmd.op = tcw_pkg::OP_NOP;
		endcase
		push_cmd.ch        = in_ch;
		push_cmd.attr      = (in_attr == 8'd0) ? dflt_attr_q : in_attr;
		push_cmd.at_cursor = in_at_cursor && (s_axis_tuser == tcw_pkg::CMD_PUT);
		// out-of-range coordinates clamp to the last row and column
		push_cmd.row = (in_row > tcw_pkg::ROW_W_MAX'(ROWS - 1))
			? tcw_pkg::ROW_W_MAX'(ROWS - 1) : in_row;
		push_cmd.col = (in_col > tcw_pkg::COL_W_MAX'(COLS - 1))
			? tcw_pkg::COL_W_MAX'(COLS - 1) : in_col;
	end

endmodule

// File: design/tcw_queue.sv
// tcw_queue: small command queue between the front and back parts
// holds decoded commands; uses tcw_pkg
module tcw_queue #(
	parameter int DEPTH = tcw_pkg::QUEUE_DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push_valid,
	output logic          push_ready,
	input  tcw_pkg::cmd_t push_cmd,
	output logic          pop_valid,
	input  logic          pop_ready,
	output tcw_pkg::cmd_t pop_cmd
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int NW = $clog2(DEPTH + 1);

	tcw_pkg::cmd_t entries_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [NW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign push_ready = (count_q != NW'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_cmd    = entries_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// File: design/tcw_back.sv
// tcw_back: execution side of the console writer
// owns the cell store, cursor, scroll and clear sweeps and the result register; uses tcw_pkg
module tcw_back #(
	parameter int ROWS = tcw_pkg::ROWS_DEF,
	parameter int COLS = tcw_pkg::COLS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          pop_valid,
	output logic          pop_ready,
	input  tcw_pkg::cmd_t pop_cmd,
	output logic          m_axis_tvalid,
	input  logic          m_axis_tready,
	output logic [31:0]   m_axis_tdata   // cursor_row, cursor_col, scrolled, read_char, read_attr
);

	localparam int NCELL = ROWS * COLS;
	localparam int MOVE  = (ROWS - 1) * COLS;
	localparam int AW    = $clog2(NCELL);
	localparam int RW    = $clog2(ROWS);
	localparam int CW    = $clog2(COLS);

	tcw_pkg::state_t state_q;
	tcw_pkg::state_t state_d;
	tcw_pkg::cmd_t   cmd_q;

	logic [15:0]   mem [NCELL];
	logic [15:0]   rd_data_q;
	logic [RW-1:0] cur_row_q;
	logic [CW-1:0] cur_col_q;
	logic [AW-1:0] cnt_q;
	logic          mv_vld_s1;
	logic [AW-1:0] mv_addr_s1;
	logic          scr_q;
	logic          out_vld_q;
	logic [31:0]   out_data_q;

	logic [RW-1:0] tgt_row;
	logic [CW-1:0] tgt_col;
	logic [AW-1:0] addr_exec;
	logic          is_put;
	logic          last_col;
	logic          last_row;
	logic          wrap_row;
	logic          need_scroll;
	logic [RW-1:0] nrow;
	logic [CW-1:0] ncol;
	logic          out_free;

	logic          we;
	logic [AW-1:0] waddr;
	logic [15:0]   wdata;
	logic          re;
	logic [AW-1:0] raddr;
	logic          out_load;
	logic [RW-1:0] res_row;
	logic [CW-1:0] res_col;
	logic          res_scr;
	logic [15:0]   res_rd;

	assign tgt_row   = cmd_q.at_cursor ? cur_row_q : RW'(cmd_q.row);
	assign tgt_col   = cmd_q.at_cursor ? cur_col_q : CW'(cmd_q.col);
	assign addr_exec = AW'(tgt_row * COLS + tgt_col);
	assign is_put    = (cmd_q.op == tcw_pkg::OP_PUT) || (cmd_q.op == tcw_pkg::OP_NEWLINE);
	assign last_col  = (tgt_col == CW'(COLS - 1));
	assign last_row  = (tgt_row == RW'(ROWS - 1));
	assign wrap_row  = (cmd_q.op == tcw_pkg::OP_NEWLINE) || last_col;
	assign need_scroll = is_put && wrap_row && last_row;
	assign out_free  = !out_vld_q || m_axis_tready;

	// cursor after the current command
	always_comb begin
		nrow = cur_row_q;
		ncol = cur_col_q;
		if (is_put) begin
			if (!wrap_row) begin
				nrow = tgt_row;
				ncol = tgt_col + 1'b1;
			end else if (last_row) begin
				nrow = RW'(ROWS - 1);
				ncol = '0;
			end else begin
				nrow = tgt_row + 1'b1;
				ncol = '0;
			end
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			tcw_pkg::ST_INIT: begin
				if (cnt_q == AW'(NCELL - 1)) state_d = tcw_pkg::ST_IDLE;
			end
			tcw_pkg::ST_IDLE: begin
				if (pop_valid) state_d = tcw_pkg::ST_EXEC;
			end
			tcw_pkg::ST_EXEC: begin
				unique case (cmd_q.op)
					tcw_pkg::OP_READ:  state_d = tcw_pkg::ST_DONE;
					tcw_pkg::OP_CLEAR: state_d = tcw_pkg::ST_CLEAR;
					default: begin
						if (need_scroll) state_d = tcw_pkg::ST_SCROLL;
						else if (out_free) state_d = tcw_pkg::ST_IDLE;
						else state_d = tcw_pkg::ST_DONE;
					end
				endcase
			end
			tcw_pkg::ST_SCROLL: begin
				if (cnt_q == AW'(MOVE - 1)) state_d = tcw_pkg::ST_SCRBOT;
			end
			tcw_pkg::ST_SCRBOT: begin
				if (!mv_vld_s1 && cnt_q == AW'(NCELL - 1)) state_d = tcw_pkg::ST_DONE;
			end
			tcw_pkg::ST_CLEAR: begin
				if (cnt_q == AW'(NCELL - 1)) state_d = tcw_pkg::ST_DONE;
			end
			tcw_pkg::ST_DONE: begin
				if (out_free) state_d = tcw_pkg::ST_IDLE;
			end
			default: state_d = tcw_pkg::ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		pop_ready = 1'b0;
		we        = 1'b0;
		waddr     = cnt_q;
		wdata     = '0;
		re        = 1'b0;
		raddr     = addr_exec;
		out_load  = 1'b0;
		res_row   = cur_row_q;
		res_col   = cur_col_q;
		res_scr   = scr_q;
		res_rd    = (cmd_q.op == tcw_pkg::OP_READ) ? rd_data_q : '0;
		unique case (state_q)
			tcw_pkg::ST_INIT, tcw_pkg::ST_CLEAR: begin
				we = 1'b1;
			end
			tcw_pkg::ST_IDLE: begin
				pop_ready = 1'b1;
			end
			tcw_pkg::ST_EXEC: begin
				if (cmd_q.op == tcw_pkg::OP_PUT) begin
					we    = 1'b1;
					waddr = addr_exec;
					wdata = {cmd_q.attr, cmd_q.ch};
				end
				if (cmd_q.op == tcw_pkg::OP_READ) begin
					re = 1'b1;
				end
				if (cmd_q.op != tcw_pkg::OP_READ && cmd_q.op != tcw_pkg::OP_CLEAR
						&& !need_scroll && out_free) begin
					out_load = 1'b1;
					res_row  = nrow;
					res_col  = ncol;
					res_scr  = 1'b0;
					res_rd   = '0;
				end
			end
			tcw_pkg::ST_SCROLL: begin
				re    = 1'b1;
				raddr = cnt_q + AW'(COLS);
				if (mv_vld_s1) begin
					we    = 1'b1;
					waddr = mv_addr_s1;
					wdata = rd_data_q;
				end
			end
			tcw_pkg::ST_SCRBOT: begin
				we = 1'b1;
				if (mv_vld_s1) begin
					waddr = mv_addr_s1;
					wdata = rd_data_q;
				end
			end
			tcw_pkg::ST_DONE: begin
				out_load = out_free;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rd_data_q <= mem[raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == tcw_pkg::ST_IDLE && pop_valid) begin
			cmd_q <= pop_cmd;
		end
		mv_addr_s1 <= cnt_q;
		if (out_load) begin
			out_data_q <= {3'b000, res_rd[15:8], res_rd[7:0], res_scr, 7'(res_col), 5'(res_row)};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= tcw_pkg::ST_INIT;
			cur_row_q <= '0;
			cur_col_q <= '0;
			cnt_q     <= '0;
			mv_vld_s1 <= 1'b0;
			scr_q     <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			mv_vld_s1 <= (state_q == tcw_pkg::ST_SCROLL);
			if (state_q == tcw_pkg::ST_EXEC) begin
				cur_row_q <= nrow;
				cur_col_q <= ncol;
				scr_q     <= need_scroll;
				cnt_q     <= '0;
			end else if (state_q == tcw_pkg::ST_INIT || state_q == tcw_pkg::ST_CLEAR
					|| state_q == tcw_pkg::ST_SCROLL
					|| (state_q == tcw_pkg::ST_SCRBOT && !mv_vld_s1)) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = out_data_q;

endmodule

// File: design/text_console_writer_core.sv
// text_console_writer_core: top level of the character-cell text console writer
// joins tcw_front, tcw_queue and tcw_back; uses tcw_pkg
//
// Items arrive on the s_axis channel, command in tuser and the put or read
// arguments in tdata; each item gives exactly one result on m_axis with the
// cursor after the item, a scroll flag and, for a read, the cell contents.
// cfg_valid/cfg_data loads the default attribute; cfg_ready is always high.
// A decoder stage feeds a two-entry command queue; the executing sequencer
// owns the cell store (one write and one registered read port per cycle).
// Put, newline and unused commands run through EXEC in the sequencer, and
// through DONE only while the output is full; a read always goes on to DONE.
// A clear sweeps the store at one cell per cycle. A put that runs past the
// bottom row scrolls the store up, one cell moved or cleared per cycle.
// After reset the sequencer clears all ROWS*COLS cells of the store (2000 at
// 25 by 80); the queue still takes up to two items meanwhile. The cursor
// starts at the top left and the default attribute at 15.
// A stalled receiver holds the finished result in the output register; the
// sequencer keeps working on the next item until its own result is ready.
module text_console_writer_core #(
	parameter int ROWS        = tcw_pkg::ROWS_DEF,
	parameter int COLS        = tcw_pkg::COLS_DEF,
	parameter int QUEUE_DEPTH = tcw_pkg::QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_data,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // ch, attr, at_cursor, row, col, zero pad
	input  logic [1:0]  s_axis_tuser,   // command
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata    // cursor_row, cursor_col, scrolled, read_char, read_attr
);

	logic          push_valid;
	logic          push_ready;
	tcw_pkg::cmd_t push_cmd;
	logic          pop_valid;
	logic          pop_ready;
	tcw_pkg::cmd_t pop_cmd;

	tcw_front #(
		.ROWS(ROWS),
		.COLS(COLS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.push_valid   (push_valid),
		.push_ready   (push_ready),
		.push_cmd     (push_cmd)
	);

	tcw_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_cmd  (push_cmd),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_cmd   (pop_cmd)
	);

	tcw_back #(
		.ROWS(ROWS),
		.COLS(COLS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.pop_valid    (pop_valid),
		.pop_ready    (pop_ready),
		.pop_cmd      (pop_cmd),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

endmodule
